>>> hdl/mmfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_pkg
// shared types and constants of the min-max feature scaler
// ----------------------------------------------------------------------------
package mmfs_pkg;

  localparam int DATA_W     = 32;
  localparam int FEATURE_W  = 6;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int FEAT_CMP_W = 11;  // holds any feature count up to 1024
  localparam int PROD_W     = 64;
  localparam int QUOT_W     = 41;  // quotient bits kept, larger ones saturate
  localparam int REM_W      = 32;

  localparam logic [OP_W-1:0] OP_FIT = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD = 2'd1;
  localparam logic [OP_W-1:0] OP_INV = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  localparam logic CFG_OUTPUT_LOW  = 1'b0;
  localparam logic CFG_OUTPUT_HIGH = 1'b1;

  localparam logic signed [DATA_W-1:0] Q_MAX         = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN         = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] OUT_LOW_RST   = 32'sh0000_0000;
  localparam logic signed [DATA_W-1:0] OUT_HIGH_RST  = 32'sh0001_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] lowest;
    logic signed [DATA_W-1:0] highest;
  } entry_t;

  typedef struct packed {
    logic                     start;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;
    logic [DATA_W-1:0]        mag_d;
    logic                     neg;
    logic signed [DATA_W-1:0] offset;
  } md_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;
  } md_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PREP,
    ST_CALC,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHECK,
    MD_DIV,
    MD_SIGN,
    MD_SUM
  } md_state_t;

endpackage
`default_nettype wire

>>> hdl/mmfs_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_table
// per-feature extremes memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module mmfs_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire mmfs_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output mmfs_pkg::entry_t     rdata
);

  mmfs_pkg::entry_t mem [DEPTH];
  mmfs_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hdl/mmfs_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_muldiv
// a*b/d + offset with truncation toward zero and signed 32-bit clamp
// ----------------------------------------------------------------------------
module mmfs_muldiv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mmfs_pkg::md_req_t req,
  output mmfs_pkg::md_rsp_t      rsp
);

  localparam int DW    = mmfs_pkg::DATA_W;
  localparam int PW    = mmfs_pkg::PROD_W;
  localparam int QW    = mmfs_pkg::QUOT_W;
  localparam int RW    = mmfs_pkg::REM_W;
  localparam int SW    = QW + 1;        // signed quotient
  localparam int AWID  = QW + 2;        // quotient plus offset
  localparam int CNT_W = $clog2(QW);

  mmfs_pkg::md_state_t state_r, state_nxt;
  logic [DW-1:0]        a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [DW-1:0] off_r, off_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic [QW-1:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [SW-1:0]        qs_r, qs_nxt;
  mmfs_pkg::md_rsp_t    rsp_r, rsp_nxt;

  logic [RW:0]          shifted;
  logic [RW:0]          sub;
  logic                 ge;
  logic [AWID-1:0]      sum;
  logic [SW-1:0]        q_ext;
  logic                 sum_hi, sum_lo;

  always_comb begin
    shifted = {rem_r, quo_r[QW-1]};
    sub     = shifted - {1'b0, d_r};
    ge      = shifted >= {1'b0, d_r};
    q_ext   = {1'b0, quo_r};
    sum     = {qs_r[SW-1], qs_r} + {{(AWID-DW){off_r[DW-1]}}, off_r};
    // out of range when the bits above bit 31 are not all copies of it
    sum_hi  = !sum[AWID-1] && (sum[AWID-2:DW-1] != '0);
    sum_lo  = sum[AWID-1] && (sum[AWID-2:DW-1] != '1);

    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    neg_nxt   = neg_r;
    off_nxt   = off_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    qs_nxt    = qs_r;
    rsp_nxt   = rsp_r;
    rsp_nxt.done = 1'b0;

    case (state_r)
      mmfs_pkg::MD_IDLE: begin
        if (req.start) begin
          a_nxt     = req.mag_a;
          b_nxt     = req.mag_b;
          d_nxt     = req.mag_d;
          neg_nxt   = req.neg;
          off_nxt   = req.offset;
          state_nxt = mmfs_pkg::MD_MUL;
        end
      end
      mmfs_pkg::MD_MUL: begin
        prod_nxt  = PW'(a_r) * PW'(b_r);
        state_nxt = mmfs_pkg::MD_CHECK;
      end
      mmfs_pkg::MD_CHECK: begin
        // top bits already at or above d: quotient needs more than QW bits
        if (RW'(prod_r[PW-1:QW]) >= d_r) begin
          ovf_nxt   = 1'b1;
          state_nxt = mmfs_pkg::MD_SIGN;
        end else begin
          ovf_nxt   = 1'b0;
          rem_nxt   = RW'(prod_r[PW-1:QW]);
          quo_nxt   = prod_r[QW-1:0];
          cnt_nxt   = CNT_W'(QW - 1);
          state_nxt = mmfs_pkg::MD_DIV;
        end
      end
      mmfs_pkg::MD_DIV: begin
        // restoring step, quotient bits shift in from the bottom
        rem_nxt = ge ? sub[RW-1:0] : shifted[RW-1:0];
        quo_nxt = {quo_r[QW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = mmfs_pkg::MD_SIGN;
        end
      end
      mmfs_pkg::MD_SIGN: begin
        if (!ovf_r) begin
          ovf_nxt = quo_r[QW-1] && (quo_r[QW-2:0] != '0);
        end
        qs_nxt    = neg_r ? (-q_ext) : q_ext;
        state_nxt = mmfs_pkg::MD_SUM;
      end
      mmfs_pkg::MD_SUM: begin
        rsp_nxt.done = 1'b1;
        if (ovf_r) begin
          rsp_nxt.value  = neg_r ? mmfs_pkg::Q_MIN : mmfs_pkg::Q_MAX;
          rsp_nxt.status = mmfs_pkg::STATUS_SAT;
        end else if (sum_hi) begin
          rsp_nxt.value  = mmfs_pkg::Q_MAX;
          rsp_nxt.status = mmfs_pkg::STATUS_SAT;
        end else if (sum_lo) begin
          rsp_nxt.value  = mmfs_pkg::Q_MIN;
          rsp_nxt.status = mmfs_pkg::STATUS_SAT;
        end else begin
          rsp_nxt.value  = sum[DW-1:0];
          rsp_nxt.status = mmfs_pkg::STATUS_OK;
        end
        state_nxt = mmfs_pkg::MD_IDLE;
      end
      default: begin
        state_nxt = mmfs_pkg::MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmfs_pkg::MD_IDLE;
      rsp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rsp_r   <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    d_r          <= d_nxt;
    neg_r        <= neg_nxt;
    off_r        <= off_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    ovf_r        <= ovf_nxt;
    qs_r         <= qs_nxt;
  end

  assign rsp = rsp_r;

endmodule
`default_nettype wire

>>> hdl/min_max_feature_scaler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// fit and unused op words pass through read and evaluate, degenerate scaling words
//   also through setup, forward and inverse through read, setup, 41-step divide, sum
// one word at a time: a new word is taken only after the last has reached the output
//   register; scaling words wait on the iterative 64/32 divider in mmfs_muldiv
// reset: synchronous, active low; afterwards a clearing pass over every feature entry
//   writes the extremes table before the first input word is taken
// ----------------------------------------------------------------------------
// min_max_feature_scaler_top
// per-feature min/max tracking and min-max scaling in signed Q16.16
// ----------------------------------------------------------------------------
module min_max_feature_scaler_top #(
  parameter int FEATURES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration writes
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wr_data,
  // input words
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [5:0]         in_feature,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic               in_first_sample,
  // result words
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic [1:0]              out_status
);

  localparam int AW  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int DW  = mmfs_pkg::DATA_W;
  localparam int XW  = DW + 1;                  // exact differences
  localparam int FCW = mmfs_pkg::FEAT_CMP_W;

  mmfs_pkg::ctl_state_t state_r, state_nxt;

  // configuration registers
  logic signed [DW-1:0] out_low_r, out_high_r;

  // captured input word
  logic [1:0]           op_r;
  logic                 feat_ok_r;
  logic [AW-1:0]        addr_r;
  logic signed [DW-1:0] x_r;
  logic                 first_r;

  // clearing pass index
  logic [AW-1:0]        clr_idx_r, clr_idx_nxt;

  // working values for the scaling ops
  logic signed [DW-1:0] lo_r, lo_nxt;
  logic [XW-1:0]        range_r, range_nxt;
  logic [XW-1:0]        span_r, span_nxt;
  logic [XW-1:0]        dx_r, dx_nxt;

  // pending result and output register
  logic signed [DW-1:0] res_r, res_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_value_r, out_value_nxt;
  logic [1:0]           out_status_r, out_status_nxt;

  // table port
  logic                 tbl_we;
  logic [AW-1:0]        tbl_waddr;
  mmfs_pkg::entry_t     tbl_wdata;
  mmfs_pkg::entry_t     tbl_rdata;

  mmfs_pkg::md_req_t    md_req;
  mmfs_pkg::md_rsp_t    md_rsp;

  logic                 in_accept;
  logic [FCW-1:0]       feat_ext;
  logic                 in_feat_ok;
  logic signed [DW-1:0] lo_s, hi_s;
  logic [XW-1:0]        dx_neg, span_neg, range_neg;
  logic                 range_pos, span_zero;

  assign in_stall   = (state_r != mmfs_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  // feature indexes at or beyond FEATURES read as never fitted
  assign feat_ext   = FCW'(in_feature);
  assign in_feat_ok = feat_ext < FCW'(FEATURES);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_low_r  <= mmfs_pkg::OUT_LOW_RST;
      out_high_r <= mmfs_pkg::OUT_HIGH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mmfs_pkg::CFG_OUTPUT_LOW:  out_low_r  <= cfg_wr_data;
        mmfs_pkg::CFG_OUTPUT_HIGH: out_high_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r      <= in_op;
      feat_ok_r <= in_feat_ok;
      addr_r    <= in_feat_ok ? AW'(feat_ext) : '0;
      x_r       <= in_sample_value;
      first_r   <= in_first_sample;
    end
  end

  mmfs_table #(
    .DEPTH (FEATURES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (addr_r),
    .rdata (tbl_rdata)
  );

  mmfs_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  always_comb begin
    // invalid feature behaves like an entry that was never fitted
    lo_s      = feat_ok_r ? tbl_rdata.lowest  : mmfs_pkg::Q_MAX;
    hi_s      = feat_ok_r ? tbl_rdata.highest : mmfs_pkg::Q_MIN;
    dx_neg    = -dx_r;
    span_neg  = -span_r;
    range_neg = -range_r;
    range_pos = !range_r[XW-1] && (range_r != '0);
    span_zero = (span_r == '0);

    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    lo_nxt         = lo_r;
    range_nxt      = range_r;
    span_nxt       = span_r;
    dx_nxt         = dx_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    tbl_we    = 1'b0;
    tbl_waddr = addr_r;
    tbl_wdata = '{lowest: mmfs_pkg::Q_MAX, highest: mmfs_pkg::Q_MIN};

    md_req        = '0;
    md_req.offset = out_low_r;

    case (state_r)
      mmfs_pkg::ST_CLEAR: begin
        tbl_we      = 1'b1;
        tbl_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(FEATURES - 1)) begin
          state_nxt = mmfs_pkg::ST_IDLE;
        end
      end
      mmfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mmfs_pkg::ST_READ;
        end
      end
      mmfs_pkg::ST_READ: begin
        // table read in flight
        state_nxt = mmfs_pkg::ST_EVAL;
      end
      mmfs_pkg::ST_EVAL: begin
        lo_nxt     = lo_s;
        range_nxt  = {hi_s[DW-1], hi_s} - {lo_s[DW-1], lo_s};
        span_nxt   = {out_high_r[DW-1], out_high_r} - {out_low_r[DW-1], out_low_r};
        if (op_r == mmfs_pkg::OP_INV) begin
          dx_nxt = {x_r[DW-1], x_r} - {out_low_r[DW-1], out_low_r};
        end else begin
          dx_nxt = {x_r[DW-1], x_r} - {lo_s[DW-1], lo_s};
        end
        res_nxt    = '0;
        status_nxt = mmfs_pkg::STATUS_OK;
        if (op_r == mmfs_pkg::OP_FIT) begin
          tbl_we = feat_ok_r;
          if (first_r) begin
            tbl_wdata = '{lowest: x_r, highest: x_r};
          end else begin
            tbl_wdata.lowest  = (x_r < lo_s) ? x_r : lo_s;
            tbl_wdata.highest = (x_r > hi_s) ? x_r : hi_s;
          end
          state_nxt = mmfs_pkg::ST_OUT;
        end else if (op_r == mmfs_pkg::OP_FWD || op_r == mmfs_pkg::OP_INV) begin
          state_nxt = mmfs_pkg::ST_PREP;
        end else begin
          state_nxt = mmfs_pkg::ST_OUT;
        end
      end
      mmfs_pkg::ST_PREP: begin
        if (op_r == mmfs_pkg::OP_FWD) begin
          if (!range_pos) begin
            res_nxt    = '0;
            status_nxt = mmfs_pkg::STATUS_DEGEN;
            state_nxt  = mmfs_pkg::ST_OUT;
          end else begin
            md_req.start  = 1'b1;
            md_req.mag_a  = dx_r[XW-1] ? dx_neg[DW-1:0] : dx_r[DW-1:0];
            md_req.mag_b  = span_r[XW-1] ? span_neg[DW-1:0] : span_r[DW-1:0];
            md_req.mag_d  = range_r[DW-1:0];
            md_req.neg    = dx_r[XW-1] ^ span_r[XW-1];
            md_req.offset = out_low_r;
            state_nxt     = mmfs_pkg::ST_CALC;
          end
        end else begin
          // inverse: degenerate input range or zero output span gives lowest
          if (!range_pos || span_zero) begin
            res_nxt    = lo_r;
            status_nxt = mmfs_pkg::STATUS_DEGEN;
            state_nxt  = mmfs_pkg::ST_OUT;
          end else begin
            md_req.start  = 1'b1;
            md_req.mag_a  = dx_r[XW-1] ? dx_neg[DW-1:0] : dx_r[DW-1:0];
            md_req.mag_b  = range_r[XW-1] ? range_neg[DW-1:0] : range_r[DW-1:0];
            md_req.mag_d  = span_r[XW-1] ? span_neg[DW-1:0] : span_r[DW-1:0];
            md_req.neg    = dx_r[XW-1] ^ span_r[XW-1];
            md_req.offset = lo_r;
            state_nxt     = mmfs_pkg::ST_CALC;
          end
        end
      end
      mmfs_pkg::ST_CALC: begin
        if (md_rsp.done) begin
          res_nxt    = md_rsp.value;
          status_nxt = md_rsp.status;
          state_nxt  = mmfs_pkg::ST_OUT;
        end
      end
      mmfs_pkg::ST_OUT: begin
        // output register free or emptying this cycle
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_status_nxt = status_r;
          state_nxt      = mmfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmfs_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    range_r      <= range_nxt;
    span_r       <= span_nxt;
    dx_r         <= dx_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

`ifndef SYNTH
  // table is written only by the clearing pass or by a fit word
  a_table_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (state_r == mmfs_pkg::ST_CLEAR) ||
               (state_r == mmfs_pkg::ST_EVAL && op_r == mmfs_pkg::OP_FIT))
    else $error("table write outside clear or fit");

  // the divider answers only while the controller waits for it
  a_md_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> state_r == mmfs_pkg::ST_CALC)
    else $error("divider result with no pending request");

  // an accepted word always starts with the table read
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == mmfs_pkg::ST_READ)
    else $error("accepted word did not start a table read");
`endif

endmodule
`default_nettype wire
